>>> sv/bwig_pkg.sv
// Package for the bilinear weight and index generator.
// Holds widths, register indexes, status and opcode codes. No dependencies.
package bwig_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int NEIGHBOR_COUNT = 4;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = $clog2(NEIGHBOR_COUNT);
  localparam int IDX_W = 24;
  localparam int SLOT_W = 10;
  localparam int WGT_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_X   = 3'd5;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOB     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;
endpackage

>>> sv/bwig_if.sv
// Channel interfaces: input items, result items and configuration writes.
// Depends on bwig_pkg.
interface bwig_in_if (input logic clk);
  logic valid;
  logic ready;
  logic opcode;
  logic signed [31:0] z_position;
  logic signed [31:0] x_position;
  modport source (output valid, opcode, z_position, x_position, input ready);
  modport sink (input valid, opcode, z_position, x_position, output ready);
endinterface

interface bwig_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [bwig_pkg::IDX_W-1:0] grid_index;
  logic [bwig_pkg::SLOT_W-1:0] slot;
  logic [bwig_pkg::WGT_W-1:0] weight;
  logic is_new;
  logic [1:0] status;
  logic last;
  modport source (output valid, grid_index, slot, weight, is_new, status, last, input ready);
  modport sink (input valid, grid_index, slot, weight, is_new, status, last, output ready);
endinterface

interface bwig_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [bwig_pkg::CFG_IDX_W-1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/bilinear_weight_index_generator.sv
// Top level of the bilinear weight and index generator with unique point table.
// Depends on bwig_pkg and the interfaces in bwig_if.sv.
//
//  channel | dir | payload
//  in_     | in  | opcode, z_position, x_position
//  out_    | out | grid_index, slot, weight, is_new, status, last
//  cfg_    | in  | index, data
//
// A place item passes S_MULZ, S_MULX, S_CHK and S_BASE to map and bounds-check both axes.
// Each of the four points then passes S_WGT and S_SCAN for setup, a table scan of the
// stored entries (at least one step) through the single read port, S_EMIT to load the
// result and S_WAIT until it is taken. Clear items are answered from S_IDLE and
// out-of-bounds items from S_BASE. Reset zeroes point_count.
// A stalled result holds in the output register; the next item is taken once it leaves.
module bilinear_weight_index_generator (
  input logic clk,
  input logic rst_n,
  bwig_in_if.sink in_ch,
  bwig_out_if.source out_ch,
  bwig_cfg_if.sink cfg_ch
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MULZ = 4'd1, S_MULX = 4'd2, S_CHK = 4'd3,
    S_BASE = 4'd4, S_WGT = 4'd5, S_SCAN = 4'd6, S_CMP = 4'd7, S_EMIT = 4'd8,
    S_WAIT = 4'd9;
  localparam int IDXW = bwig_pkg::IDX_W;

  logic signed [31:0] origin_z_r, origin_x_r;
  logic [23:0] inv_z_r, inv_x_r;
  logic [12:0] rows_r, cols_r;

  logic [3:0] state_r;
  logic signed [31:0] zp_r, xp_r;
  logic signed [56:0] prod_r, prod_nxt;
  logic [31:0] gz_r, gx_r;
  logic okz_r, okx_r;
  logic [IDXW-1:0] base_r;
  logic [16:0] wz_r, wx_r;
  logic [bwig_pkg::NW-1:0] k_r;
  logic [bwig_pkg::CW-1:0] cnt_r, s_r;
  logic [IDXW-1:0] key_r;
  logic [16:0] wk_r;

  logic [IDXW-1:0] mem [bwig_pkg::TABLE_DEPTH];
  logic [IDXW-1:0] rd_r;
  logic we;
  logic [bwig_pkg::AW-1:0] wa;

  logic ov_r;
  logic [IDXW-1:0] o_idx_r;
  logic [bwig_pkg::SLOT_W-1:0] o_slot_r;
  logic [bwig_pkg::WGT_W-1:0] o_w_r;
  logic o_new_r, o_last_r;
  logic [1:0] o_st_r;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.grid_index = o_idx_r;
  assign out_ch.slot = o_slot_r;
  assign out_ch.weight = o_w_r;
  assign out_ch.is_new = o_new_r;
  assign out_ch.status = o_st_r;
  assign out_ch.last = o_last_r;

  // axis map: one signed 33x25 product per cycle
  logic signed [32:0] diff;
  logic signed [24:0] inv_s;
  always_comb begin
    if (state_r == S_MULZ) begin
      diff = {zp_r[31], zp_r} - {origin_z_r[31], origin_z_r};
      inv_s = {1'b0, inv_z_r};
    end else begin
      diff = {xp_r[31], xp_r} - {origin_x_r[31], origin_x_r};
      inv_s = {1'b0, inv_x_r};
    end
    prod_nxt = 57'(diff * inv_s);
  end

  function automatic logic axis_ok(input logic signed [56:0] p, input logic [12:0] n);
    logic [40:0] v;
    logic signed [14:0] hi;
    begin
      v = p[56:16];
      hi = $signed({2'b00, n}) - 15'sd2;
      axis_ok = (p > 0) && (v > 41'(bwig_pkg::ONE_Q16)) && (hi > 0)
        && (v < {hi[12:0], 16'h0});
    end
  endfunction

  // weight product of neighbor k
  logic [16:0] az, ax;
  logic [33:0] wprod;
  always_comb begin
    az = k_r[0] ? (bwig_pkg::ONE_Q16 - wz_r) : wz_r;
    ax = k_r[1] ? (bwig_pkg::ONE_Q16 - wx_r) : wx_r;
    wprod = az * ax;
  end

  // rd_r holds entry s_r-1; only entries below point_count count as a match
  logic hit;
  assign hit = (s_r != 0) && (s_r <= cnt_r) && (rd_r == key_r);
  logic full;
  assign full = (cnt_r == bwig_pkg::CW'(bwig_pkg::TABLE_DEPTH));

  assign we = (state_r == S_CMP) && !hit && (s_r >= cnt_r) && !full && !ov_r;
  assign wa = cnt_r[bwig_pkg::AW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= key_r;
    rd_r <= mem[s_r[bwig_pkg::AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_z_r <= '0; origin_x_r <= '0;
      inv_z_r <= 24'd65536; inv_x_r <= 24'd65536;
      rows_r <= 13'd256; cols_r <= 13'd256;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bwig_pkg::REG_ORIGIN_Z: origin_z_r <= cfg_ch.data;
        bwig_pkg::REG_ORIGIN_X: origin_x_r <= cfg_ch.data;
        bwig_pkg::REG_INV_Z:    inv_z_r <= cfg_ch.data[23:0];
        bwig_pkg::REG_INV_X:    inv_x_r <= cfg_ch.data[23:0];
        bwig_pkg::REG_ROWS_Z:   rows_r <= cfg_ch.data[12:0];
        bwig_pkg::REG_COLS_X:   cols_r <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && !ov_r) begin
          zp_r <= in_ch.z_position;
          xp_r <= in_ch.x_position;
          if (in_ch.opcode == bwig_pkg::OP_CLEAR) begin
            cnt_r <= '0;
            ov_r <= 1'b1;
            {o_idx_r, o_slot_r, o_w_r, o_new_r} <= '0;
            o_st_r <= bwig_pkg::ST_CLEARED;
            o_last_r <= 1'b1;
          end else state_r <= S_MULZ;
        end
        S_MULZ: begin prod_r <= prod_nxt; state_r <= S_MULX; end
        S_MULX: begin
          okz_r <= axis_ok(prod_r, rows_r);
          gz_r <= prod_r[47:16];
          prod_r <= prod_nxt;
          state_r <= S_CHK;
        end
        S_CHK: begin
          okx_r <= axis_ok(prod_r, cols_r);
          gx_r <= prod_r[47:16];
          state_r <= S_BASE;
        end
        S_BASE: begin
          if (!(okz_r && okx_r)) begin
            ov_r <= 1'b1;
            {o_idx_r, o_slot_r, o_w_r, o_new_r} <= '0;
            o_st_r <= bwig_pkg::ST_OOB;
            o_last_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            base_r <= IDXW'(gx_r[31:16] * rows_r) + IDXW'(gz_r[31:16]);
            wz_r <= bwig_pkg::ONE_Q16 - {1'b0, gz_r[15:0]};
            wx_r <= bwig_pkg::ONE_Q16 - {1'b0, gx_r[15:0]};
            k_r <= '0;
            state_r <= S_WGT;
          end
        end
        S_WGT: begin
          wk_r <= wprod[32:16];
          key_r <= base_r + (k_r[0] ? IDXW'(1) : '0) + (k_r[1] ? IDXW'(rows_r) : '0);
          s_r <= '0;
          state_r <= S_SCAN;
        end
        // s_r addresses the memory; rd_r shows entry s_r-1 in S_CMP
        S_SCAN: begin s_r <= s_r + 1'b1; state_r <= S_CMP; end
        S_CMP: if (!ov_r) begin
          if (hit) begin
            o_slot_r <= bwig_pkg::SLOT_W'(s_r - 1'b1);
            o_new_r <= 1'b0; o_st_r <= bwig_pkg::ST_OK;
            state_r <= S_EMIT;
          end else if (s_r >= cnt_r) begin
            if (full) begin
              o_slot_r <= '0; o_new_r <= 1'b0; o_st_r <= bwig_pkg::ST_FULL;
            end else begin
              o_slot_r <= bwig_pkg::SLOT_W'(cnt_r);
              o_new_r <= 1'b1; o_st_r <= bwig_pkg::ST_OK;
              cnt_r <= cnt_r + 1'b1;
            end
            state_r <= S_EMIT;
          end else s_r <= s_r + 1'b1;
        end
        S_EMIT: begin
          ov_r <= 1'b1;
          o_idx_r <= key_r;
          o_w_r <= wk_r;
          o_last_r <= (k_r == bwig_pkg::NW'(bwig_pkg::NEIGHBOR_COUNT - 1));
          state_r <= S_WAIT;
        end
        S_WAIT: if (!ov_r) begin
          k_r <= k_r + 1'b1;
          state_r <= (o_last_r) ? S_IDLE : S_WGT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/bwig_checker.sv
// Port-level checks for the bilinear weight and index generator, bound to the top.
// Depends on bwig_pkg and the interfaces in bwig_if.sv.
module bwig_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid, in_ready, in_opcode,
  input logic out_valid, out_ready, out_is_new, out_last,
  input logic [1:0] out_status,
  input logic [bwig_pkg::WGT_W-1:0] out_weight
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == bwig_pkg::OP_CLEAR |=>
      out_valid && out_status == bwig_pkg::ST_CLEARED && out_last)
    else $error("clear result missing");
  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_new |-> out_status == bwig_pkg::ST_OK)
    else $error("new point with bad status");
  a_oob: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bwig_pkg::ST_OOB || out_status == bwig_pkg::ST_CLEARED)
      |-> out_last && out_weight == '0)
    else $error("single result not final");
endmodule

bind bilinear_weight_index_generator bwig_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_opcode(in_ch.opcode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_is_new(out_ch.is_new),
  .out_last(out_ch.last), .out_status(out_ch.status), .out_weight(out_ch.weight)
);

>>> tb/tb_bilinear_weight_index_generator.sv
// Testbench for bilinear_weight_index_generator: directed and random place and clear
// transfers, checked against an in-bench predictor of weights, indexes and point table.
// Depends on bwig_pkg, the channel interfaces in bwig_if.sv and the block itself.
module tb_bilinear_weight_index_generator;

  typedef struct packed {
    logic [bwig_pkg::IDX_W-1:0]  grid_index;
    logic [bwig_pkg::SLOT_W-1:0] slot;
    logic [bwig_pkg::WGT_W-1:0]  weight;
    logic                        is_new;
    logic [1:0]                  status;
    logic                        last;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bwig_in_if  in_ch (clk);
  bwig_out_if out_ch (clk);
  bwig_cfg_if cfg_ch (clk);

  bilinear_weight_index_generator DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0]         org_z, org_x;
  logic [23:0]                inv_z, inv_x;
  logic [12:0]                n_rows, n_cols;
  logic [bwig_pkg::IDX_W-1:0] points [bwig_pkg::TABLE_DEPTH];
  int                         n_points;

  grid_result_t expected_q[$];
  int           error_count = 0;
  bit           gaps_on = 1'b1;
  bit           long_hold_req = 1'b0;
  longint       cycle_count = 0;

  task automatic queue_result(grid_result_t r);
    expected_q = {expected_q, r};
  endtask

  function automatic bit to_grid(logic signed [31:0] p, logic signed [31:0] o,
                                 logic [23:0] inv, logic [12:0] n, output longint g);
    longint diff, prod, hi;
    diff = longint'(p) - longint'(o);
    prod = diff * longint'({40'd0, inv});
    hi = (longint'({51'd0, n}) - 2) * 65536;
    g = 0;
    if (prod <= 0) return 1'b0;
    g = prod >>> 16;
    if (g <= 65536) return 1'b0;
    if (hi <= 0 || g >= hi) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_item(logic op, logic signed [31:0] zp, logic signed [31:0] xp);
    longint gz, gx;
    logic [31:0] zc, xc;
    longint wz, wx;
    logic [bwig_pkg::IDX_W-1:0] base;
    logic [bwig_pkg::IDX_W-1:0] idx [4];
    longint wt [4];
    grid_result_t r;
    bit ok_z, ok_x, found;
    r = '0;
    if (op == bwig_pkg::OP_CLEAR) begin
      n_points = 0;
      r.status = bwig_pkg::ST_CLEARED;
      r.last = 1'b1;
      queue_result(r);
      return;
    end
    ok_z = to_grid(zp, org_z, inv_z, n_rows, gz);
    ok_x = to_grid(xp, org_x, inv_x, n_cols, gx);
    if (!ok_z || !ok_x) begin
      r.status = bwig_pkg::ST_OOB;
      r.last = 1'b1;
      queue_result(r);
      return;
    end
    zc = 32'(gz >> 16);
    xc = 32'(gx >> 16);
    wz = 65536 - (gz & 16'hFFFF);
    wx = 65536 - (gx & 16'hFFFF);
    base = bwig_pkg::IDX_W'(xc * {19'd0, n_rows} + zc);
    idx[0] = base;
    idx[1] = base + 1;
    idx[2] = base + bwig_pkg::IDX_W'(n_rows);
    idx[3] = base + bwig_pkg::IDX_W'(n_rows) + 1;
    wt[0] = (wz * wx) >> 16;
    wt[1] = ((65536 - wz) * wx) >> 16;
    wt[2] = (wz * (65536 - wx)) >> 16;
    wt[3] = ((65536 - wz) * (65536 - wx)) >> 16;
    // look up in order so later corners see points appended by earlier ones
    for (int k = 0; k < 4; k++) begin
      r = '0;
      r.grid_index = idx[k];
      r.weight = bwig_pkg::WGT_W'(wt[k]);
      r.status = bwig_pkg::ST_OK;
      r.last = (k == 3);
      found = 1'b0;
      for (int s = 0; s < n_points; s++) begin
        if (!found && points[s] == idx[k]) begin
          found = 1'b1;
          r.slot = bwig_pkg::SLOT_W'(s);
        end
      end
      if (!found) begin
        if (n_points < bwig_pkg::TABLE_DEPTH) begin
          points[n_points] = idx[k];
          r.slot = bwig_pkg::SLOT_W'(n_points);
          r.is_new = 1'b1;
          n_points++;
        end else begin
          r.status = bwig_pkg::ST_FULL;
        end
      end
      queue_result(r);
    end
  endtask

  task automatic send_item(logic op, logic signed [31:0] zp, logic signed [31:0] xp);
    bit hit;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.z_position <= zp;
    in_ch.x_position <= xp;
    do begin
      @(negedge clk);
      hit = in_ch.ready;
      @(posedge clk);
    end while (!hit);
    predict_item(op, zp, xp);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    // a clear or out-of-bounds item may still be finishing
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [bwig_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    bit hit;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do begin
      @(negedge clk);
      hit = cfg_ch.ready;
      @(posedge clk);
    end while (!hit);
    cfg_ch.valid <= 1'b0;
    case (idx)
      bwig_pkg::REG_ORIGIN_Z: org_z = data;
      bwig_pkg::REG_ORIGIN_X: org_x = data;
      bwig_pkg::REG_INV_Z:    inv_z = data[23:0];
      bwig_pkg::REG_INV_X:    inv_x = data[23:0];
      bwig_pkg::REG_ROWS_Z:   n_rows = data[12:0];
      bwig_pkg::REG_COLS_X:   n_cols = data[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_grid(logic [31:0] oz, logic [31:0] ox, logic [23:0] iz,
                           logic [23:0] ix, logic [12:0] nr, logic [12:0] nc);
    write_reg(bwig_pkg::REG_ORIGIN_Z, oz);
    write_reg(bwig_pkg::REG_ORIGIN_X, ox);
    write_reg(bwig_pkg::REG_INV_Z, {8'd0, iz});
    write_reg(bwig_pkg::REG_INV_X, {8'd0, ix});
    write_reg(bwig_pkg::REG_ROWS_Z, {19'd0, nr});
    write_reg(bwig_pkg::REG_COLS_X, {19'd0, nc});
  endtask

  // position whose grid coordinate lands near g (Q.16) under the current setting
  function automatic logic signed [31:0] pos_for(longint g, logic signed [31:0] o,
                                                 logic [23:0] inv);
    return 32'(longint'(o) + (g * 65536) / longint'({40'd0, inv}));
  endfunction

  task automatic test_defaults();
    send_item(bwig_pkg::OP_CLEAR, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(bwig_pkg::OP_PLACE, 32'h0001_0000, 32'h0005_0000);  // z exactly at 1.0
    send_item(bwig_pkg::OP_PLACE, 32'h0001_0001, 32'h0005_0000);  // just past 1.0
    send_item(bwig_pkg::OP_PLACE, 32'h00FE_0000, 32'h0005_0000);  // z at n-2
    send_item(bwig_pkg::OP_PLACE, 32'h00FD_FFFF, 32'h00FD_FFFF);  // under n-2, max fraction
    send_item(bwig_pkg::OP_PLACE, 32'h0005_0000, 32'h0007_0000);  // zero fraction
    send_item(bwig_pkg::OP_PLACE, 32'h0005_8000, 32'h0007_4000);  // shares corners
    send_item(bwig_pkg::OP_PLACE, 32'h8000_0000, 32'h0005_0000);
    send_item(bwig_pkg::OP_PLACE, 32'h0005_0000, 32'h7FFF_FFFF);
    send_item(bwig_pkg::OP_PLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bwig_pkg::OP_PLACE, 32'h0000_0000, 32'h0000_0000);
    send_item(bwig_pkg::OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_item(bwig_pkg::OP_PLACE, 32'h0005_0000, 32'h0007_0000);  // slots restart
    drain();
  endtask

  task automatic test_config_extremes();
    load_grid(32'h8000_0000, 32'h7FFF_0000, 24'hFF_FFFF, 24'd1, 13'd4096, 13'd4096);
    send_item(bwig_pkg::OP_PLACE, 32'h8000_0003, 32'h7FFF_0000);
    send_item(bwig_pkg::OP_PLACE, 32'h8000_0100, 32'h7FFF_FFFF);
    send_item(bwig_pkg::OP_PLACE, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    load_grid(32'h7FFF_FFFF, 32'h8000_0000, 24'd1, 24'hFF_FFFF, 13'd3, 13'd3);
    send_item(bwig_pkg::OP_PLACE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(bwig_pkg::OP_PLACE, 32'h7FFF_FFFF, 32'h8000_0004);
    drain();
    load_grid(32'h0, 32'h0, 24'h01_0000, 24'h01_0000, 13'd4, 13'd4096);
    send_item(bwig_pkg::OP_PLACE, 32'h0001_8000, 32'h0001_8000);
    send_item(bwig_pkg::OP_PLACE, 32'h0001_8000, 32'h0FFD_8000);
    send_item(bwig_pkg::OP_CLEAR, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_table_fill();
    load_grid(32'h0, 32'h0, 24'h01_0000, 24'h01_0000, 13'd4096, 13'd4096);
    send_item(bwig_pkg::OP_CLEAR, 32'h0, 32'h0);
    // disjoint cells: four new points each
    for (int i = 0; i < 40; i++)
      send_item(bwig_pkg::OP_PLACE,
                ((2 + 2 * (i % 8)) << 16) | $urandom_range(0, 16'hFFFF),
                ((2 + 2 * (i / 8)) << 16) | $urandom_range(0, 16'hFFFF));
    send_item(bwig_pkg::OP_PLACE, 32'h0002_0000, 32'h0002_0000);  // all present
    send_item(bwig_pkg::OP_PLACE, 32'h0003_0000, 32'h0002_0000);  // straddles two cells
    send_item(bwig_pkg::OP_CLEAR, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_item(bwig_pkg::OP_PLACE, (32'(2 + i) << 16) | 32'h1234, 32'h0003_8000);
    drain();
  endtask

  task automatic test_random();
    logic [23:0] iz, ix;
    logic [12:0] nr, nc;
    logic signed [31:0] oz, ox, zp, xp;
    int pick;
    longint gz, gx;
    for (int ph = 0; ph < 4; ph++) begin
      iz = ($urandom_range(0, 1)) ? 24'h01_0000 : 24'($urandom_range(16'h4000, 24'h04_0000));
      ix = ($urandom_range(0, 1)) ? 24'h01_0000 : 24'($urandom_range(16'h4000, 24'h04_0000));
      nr = 13'($urandom_range(3, 40));
      nc = 13'($urandom_range(3, 40));
      oz = $signed($urandom) >>> 8;
      ox = $signed($urandom) >>> 8;
      if (ph == 3) gaps_on = 1'b0;
      load_grid(oz, ox, iz, ix, nr, nc);
      send_item(bwig_pkg::OP_CLEAR, $urandom, $urandom);
      for (int i = 0; i < 16; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_item(bwig_pkg::OP_CLEAR, $urandom, $urandom);
        end else if (pick < 22) begin
          send_item(bwig_pkg::OP_PLACE, $urandom, $urandom);
        end else begin
          gz = longint'($urandom_range(65536, (32'(nr) + 1) * 65536));
          gx = longint'($urandom_range(65536, (32'(nc) + 1) * 65536));
          zp = pos_for(gz, org_z, inv_z);
          xp = pos_for(gx, org_x, inv_x);
          send_item(bwig_pkg::OP_PLACE, zp, xp);
        end
      end
      drain();
    end
  endtask

  // result side: random stalls, plus one long hold-off when requested
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (long_hold_req && hold_left == 0) begin
      long_hold_req <= 1'b0;
      hold_left <= 600;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // transfer is taken at the next rising edge; ready and valid are stable here
  always @(negedge clk) begin
    grid_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: grid_index %0d status %0d", out_ch.grid_index,
               out_ch.status);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.grid_index !== want.grid_index) begin
          $error("grid_index: expected %0d, got %0d", want.grid_index, out_ch.grid_index);
          error_count++;
        end
        if (out_ch.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_ch.slot);
          error_count++;
        end
        if (out_ch.weight !== want.weight) begin
          $error("weight: expected %0d, got %0d", want.weight, out_ch.weight);
          error_count++;
        end
        if (out_ch.is_new !== want.is_new) begin
          $error("is_new: expected %0d, got %0d", want.is_new, out_ch.is_new);
          error_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 4_000_000) begin
      $display("tb_bilinear_weight_index_generator: errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = bwig_pkg::OP_PLACE;
    in_ch.z_position = '0;
    in_ch.x_position = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = bwig_pkg::REG_ORIGIN_Z;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    org_z = 0;
    org_x = 0;
    inv_z = 24'h01_0000;
    inv_x = 24'h01_0000;
    n_rows = 13'd256;
    n_cols = 13'd256;
    n_points = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_config_extremes();
    test_table_fill();
    test_backpressure();
    test_random();
    if (error_count == 0) begin
      $display("tb_bilinear_weight_index_generator: clean");
    end else begin
      $display("tb_bilinear_weight_index_generator: errors");
    end
    $finish;
  end
endmodule
